>>> design/dcvp_pkg.sv
package dcvp_pkg;

  localparam int CELL_W  = 6;
  localparam int MASK_W  = 12;
  localparam int SAMP_W  = 16;
  localparam int ISO_W   = 17;
  localparam int POS_W   = 23;
  localparam int TOTAL_W = 19;
  localparam int NUM_EDGES = 12;
  localparam logic [ISO_W-1:0] ISO_RESET = 17'd65535;

  typedef struct packed {
    logic [CELL_W-1:0] cell_x;
    logic [CELL_W-1:0] cell_y;
    logic [CELL_W-1:0] cell_z;
    logic [MASK_W-1:0] edge_mask;
    logic [SAMP_W-1:0] corner_000;
    logic [SAMP_W-1:0] corner_100;
    logic [SAMP_W-1:0] corner_010;
    logic [SAMP_W-1:0] corner_110;
    logic [SAMP_W-1:0] corner_001;
    logic [SAMP_W-1:0] corner_101;
    logic [SAMP_W-1:0] corner_011;
    logic [SAMP_W-1:0] corner_111;
  } in_req_t;

  typedef struct packed {
    logic [POS_W-1:0]   pos_x;
    logic [POS_W-1:0]   pos_y;
    logic [POS_W-1:0]   pos_z;
    logic               from_cache;
    logic               no_edges;
    logic [TOTAL_W-1:0] stored_total;
  } out_res_t;

  // per edge: start corner, end corner, varying axis
  typedef struct packed {
    logic [2:0] a;
    logic [2:0] b;
    logic [1:0] ax;
  } edge_info_t;

  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  function automatic edge_info_t edge_info(input logic [3:0] e);
    edge_info_t r;
    case (e)
      4'd0:    r = '{3'd0, 3'd1, AX_X};
      4'd1:    r = '{3'd1, 3'd5, AX_Z};
      4'd2:    r = '{3'd4, 3'd5, AX_X};
      4'd3:    r = '{3'd0, 3'd4, AX_Z};
      4'd4:    r = '{3'd2, 3'd3, AX_X};
      4'd5:    r = '{3'd3, 3'd7, AX_Z};
      4'd6:    r = '{3'd6, 3'd7, AX_X};
      4'd7:    r = '{3'd2, 3'd6, AX_Z};
      4'd8:    r = '{3'd0, 3'd2, AX_Y};
      4'd9:    r = '{3'd1, 3'd3, AX_Y};
      4'd10:   r = '{3'd5, 3'd7, AX_Y};
      4'd11:   r = '{3'd4, 3'd6, AX_Y};
      default: r = '{3'd0, 3'd0, AX_X};
    endcase
    return r;
  endfunction

  typedef struct packed {
    logic start;
    logic done;
  } div_ctl_t;

endpackage

>>> design/dual_contour_vertex_placement.sv
// a cache hit or an empty mask goes straight to the result strobe; a miss steps through every
// edge of the cell, using the shared 34-bit divider for an edge that needs it, then runs three averaging
// divisions on the same divider
// one request at a time; busy stays high until the strobe cycle
// reset: a clearing pass over all 2^(3*SIDE_BITS) entries wipes the stored flags, busy meanwhile
// results cannot be stalled by the receiver
module dual_contour_vertex_placement #(
  parameter int SIDE_BITS = 6,
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  dcvp_pkg::in_req_t                   in_req,
  output logic                                out_valid,
  output dcvp_pkg::out_res_t                  out_res,
  input  logic                                cfg_we,
  input  logic [dcvp_pkg::ISO_W-1:0]          cfg_wdata
);

  localparam int KEY_W = 3 * SIDE_BITS;
  localparam int DEPTH = 1 << KEY_W;
  localparam int NW    = dcvp_pkg::ISO_W + 1 + FRAC_BITS;
  localparam int DW    = dcvp_pkg::ISO_W + 1;
  localparam int SUM_W = FRAC_BITS + 5;
  localparam int POS_W = dcvp_pkg::POS_W;
  localparam int TOT_W = dcvp_pkg::TOTAL_W;
  localparam logic [SUM_W-1:0] ONE = SUM_W'(1) << FRAC_BITS;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_LOOK  = 4'd2;
  localparam logic [3:0] S_CHECK = 4'd3;
  localparam logic [3:0] S_EDGE  = 4'd4;
  localparam logic [3:0] S_EWAIT = 4'd5;
  localparam logic [3:0] S_AVG   = 4'd6;
  localparam logic [3:0] S_AWAIT = 4'd7;
  localparam logic [3:0] S_WRITE = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  logic [3:0]  st_r, st_nxt;
  logic [dcvp_pkg::ISO_W-1:0] iso_r;
  dcvp_pkg::in_req_t req_r;
  logic [KEY_W-1:0] key, clr_r, clr_nxt;
  logic [3:0]  e_r, e_nxt;
  logic [1:0]  k_r, k_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [SUM_W-1:0] sum_r [3];
  logic [SUM_W-1:0] sum_nxt [3];
  logic [POS_W-1:0] pos_r [3];
  logic [POS_W-1:0] pos_nxt [3];
  logic [TOT_W-1:0] total_r, total_nxt;
  logic hit_r, hit_nxt, empty_r, empty_nxt, ov_r, ov_nxt;

  dcvp_pkg::div_ctl_t dctl_in, dctl_out;
  logic [NW-1:0] dnum, dquo;
  logic [DW-1:0] dden;

  logic flag_we, flag_wd, flag_rd;
  logic [KEY_W-1:0] flag_wa;
  logic pos_we;
  logic [3*POS_W-1:0] pos_rd;

  // morton key from the low coordinate bits
  always_comb begin
    for (int i = 0; i < SIDE_BITS; i++) begin
      key[3*i]   = req_r.cell_x[i];
      key[3*i+1] = req_r.cell_y[i];
      key[3*i+2] = req_r.cell_z[i];
    end
  end

  dcvp_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_flag (
    .clk(clk), .we(flag_we), .waddr(flag_wa), .wdata(flag_wd), .raddr(key), .rdata(flag_rd)
  );

  dcvp_ram #(.WIDTH(3*POS_W), .DEPTH(DEPTH)) u_pos (
    .clk(clk), .we(pos_we), .waddr(key), .wdata({pos_r[0], pos_r[1], pos_r[2]}),
    .raddr(key), .rdata(pos_rd)
  );

  dcvp_div #(.NW(NW), .DW(DW)) u_div (
    .clk(clk), .rst_n(rst_n), .ctl_in(dctl_in), .num(dnum), .den(dden),
    .ctl_out(dctl_out), .quo(dquo)
  );

  // edge operands
  dcvp_pkg::edge_info_t ei;
  logic [dcvp_pkg::SAMP_W-1:0] corners [8];
  logic [dcvp_pkg::SAMP_W-1:0] sa, sb;
  logic signed [DW:0] enum_s, eden_s;
  logic [DW-1:0] num_abs, den_abs;
  logic num_pos;

  always_comb begin
    corners[0] = req_r.corner_000;
    corners[1] = req_r.corner_100;
    corners[2] = req_r.corner_010;
    corners[3] = req_r.corner_110;
    corners[4] = req_r.corner_001;
    corners[5] = req_r.corner_101;
    corners[6] = req_r.corner_011;
    corners[7] = req_r.corner_111;
    ei = dcvp_pkg::edge_info(e_r);
    sa = corners[ei.a];
    sb = corners[ei.b];
    enum_s = $signed({2'b00, iso_r}) - $signed({2'b00, sa, 1'b0});
    eden_s = $signed({2'b00, sb, 1'b0}) - $signed({2'b00, sa, 1'b0});
    if (eden_s < 0) begin
      enum_s = -enum_s;
      eden_s = -eden_s;
    end
    num_pos = (enum_s > 0);
    num_abs = enum_s[DW-1:0];
    den_abs = eden_s[DW-1:0];
  end

  logic [SUM_W-1:0] frac;
  logic [SUM_W-1:0] sum_k;
  logic [dcvp_pkg::CELL_W-1:0] cell_k;

  always_comb begin
    st_nxt = st_r;
    clr_nxt = clr_r;
    e_nxt = e_r;
    k_nxt = k_r;
    cnt_nxt = cnt_r;
    total_nxt = total_r;
    hit_nxt = hit_r;
    empty_nxt = empty_r;
    ov_nxt = 1'b0;
    for (int k = 0; k < 3; k++) begin
      sum_nxt[k] = sum_r[k];
      pos_nxt[k] = pos_r[k];
    end
    flag_we = 1'b0;
    flag_wa = key;
    flag_wd = 1'b1;
    pos_we = 1'b0;
    dctl_in = '{start: 1'b0, done: 1'b0};
    dnum = {num_abs, FRAC_BITS'(0)};
    dden = den_abs;
    frac = '0;
    sum_k = sum_r[k_r];
    cell_k = req_r.cell_z;
    if (k_r == dcvp_pkg::AX_X) begin
      cell_k = req_r.cell_x;
    end else if (k_r == dcvp_pkg::AX_Y) begin
      cell_k = req_r.cell_y;
    end
    case (st_r)
      S_CLEAR: begin
        flag_we = 1'b1;
        flag_wa = clr_r;
        flag_wd = 1'b0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == KEY_W'(DEPTH - 1)) begin
          st_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          st_nxt = S_LOOK;
        end
      end
      S_LOOK: st_nxt = S_CHECK;
      S_CHECK: begin
        hit_nxt = flag_rd;
        empty_nxt = 1'b0;
        e_nxt = '0;
        cnt_nxt = '0;
        for (int k = 0; k < 3; k++) begin
          sum_nxt[k] = '0;
        end
        if (flag_rd) begin
          pos_nxt[0] = pos_rd[3*POS_W-1:2*POS_W];
          pos_nxt[1] = pos_rd[2*POS_W-1:POS_W];
          pos_nxt[2] = pos_rd[POS_W-1:0];
          st_nxt = S_OUT;
        end else if (req_r.edge_mask == '0) begin
          empty_nxt = 1'b1;
          pos_nxt[0] = POS_W'({req_r.cell_x, FRAC_BITS'(0)});
          pos_nxt[1] = POS_W'({req_r.cell_y, FRAC_BITS'(0)});
          pos_nxt[2] = POS_W'({req_r.cell_z, FRAC_BITS'(0)});
          st_nxt = S_OUT;
        end else begin
          st_nxt = S_EDGE;
        end
      end
      S_EDGE: begin
        if (!req_r.edge_mask[e_r]) begin
          e_nxt = e_r + 1'b1;
          if (e_r == 4'(dcvp_pkg::NUM_EDGES - 1)) begin
            k_nxt = '0;
            st_nxt = S_AVG;
          end
        end else begin
          cnt_nxt = cnt_r + 1'b1;
          // fixed coordinates of the start corner on the other axes
          for (int k = 0; k < 3; k++) begin
            if (2'(k) != ei.ax && ei.a[k]) begin
              sum_nxt[k] = sum_r[k] + ONE;
            end
          end
          if (den_abs == '0 || !num_pos || num_abs >= den_abs) begin
            if (den_abs == '0) begin
              frac = num_pos ? ONE : '0;
            end else begin
              frac = num_pos ? ONE : '0;
            end
            sum_nxt[ei.ax] = sum_r[ei.ax] + frac;
            e_nxt = e_r + 1'b1;
            if (e_r == 4'(dcvp_pkg::NUM_EDGES - 1)) begin
              k_nxt = '0;
              st_nxt = S_AVG;
            end
          end else begin
            dctl_in.start = 1'b1;
            st_nxt = S_EWAIT;
          end
        end
      end
      S_EWAIT: begin
        if (dctl_out.done) begin
          sum_nxt[ei.ax] = sum_r[ei.ax] + SUM_W'(dquo);
          e_nxt = e_r + 1'b1;
          if (e_r == 4'(dcvp_pkg::NUM_EDGES - 1)) begin
            k_nxt = '0;
            st_nxt = S_AVG;
          end else begin
            st_nxt = S_EDGE;
          end
        end
      end
      S_AVG: begin
        dctl_in.start = 1'b1;
        dnum = NW'(sum_k);
        dden = DW'(cnt_r);
        st_nxt = S_AWAIT;
      end
      S_AWAIT: begin
        if (dctl_out.done) begin
          pos_nxt[k_r] = POS_W'(dquo + (NW'(cell_k) << FRAC_BITS));
          if (k_r == dcvp_pkg::AX_Z) begin
            st_nxt = S_WRITE;
          end else begin
            k_nxt = k_r + 1'b1;
            st_nxt = S_AVG;
          end
        end
      end
      S_WRITE: begin
        flag_we = 1'b1;
        pos_we = 1'b1;
        if (total_r < TOT_W'(DEPTH)) begin
          total_nxt = total_r + 1'b1;
        end
        st_nxt = S_OUT;
      end
      S_OUT: begin
        ov_nxt = 1'b1;
        st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLEAR;
      clr_r <= '0;
      total_r <= '0;
      iso_r <= dcvp_pkg::ISO_RESET;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      clr_r <= clr_nxt;
      total_r <= total_nxt;
      ov_r <= ov_nxt;
      if (cfg_we) begin
        iso_r <= cfg_wdata;
      end
    end
    if (start && !busy) begin
      req_r <= in_req;
    end
    e_r <= e_nxt;
    k_r <= k_nxt;
    cnt_r <= cnt_nxt;
    hit_r <= hit_nxt;
    empty_r <= empty_nxt;
    for (int k = 0; k < 3; k++) begin
      sum_r[k] <= sum_nxt[k];
      pos_r[k] <= pos_nxt[k];
    end
  end

  assign busy = (st_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_res = '{pos_x: pos_r[0], pos_y: pos_r[1], pos_z: pos_r[2],
                     from_cache: hit_r, no_edges: empty_r, stored_total: total_r};

  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(st_r) == S_OUT) else $error("result without output state");
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_res.from_cache && out_res.no_edges)) else $error("hit and empty");
  a_total: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= TOT_W'(DEPTH)) else $error("count overflow");

endmodule

>>> design/dcvp_ram.sv
module dcvp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/dcvp_div.sv
// restoring divider, one quotient bit per cycle
module dcvp_div #(
  parameter int NW = 24,
  parameter int DW = 18
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  dcvp_pkg::div_ctl_t     ctl_in,
  input  logic [NW-1:0]          num,
  input  logic [DW-1:0]          den,
  output dcvp_pkg::div_ctl_t     ctl_out,
  output logic [NW-1:0]          quo
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] q_r, q_nxt;
  logic [DW:0]   rem_r, rem_nxt;
  logic [DW-1:0] den_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          run_r, run_nxt, done_r, done_nxt;
  logic [DW:0]   trial;

  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    run_nxt = run_r;
    done_nxt = 1'b0;
    trial = {rem_r[DW-1:0], q_r[NW-1]};
    if (ctl_in.start) begin
      q_nxt = num;
      rem_nxt = '0;
      cnt_nxt = CW'(NW);
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        q_nxt = {q_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt = {q_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        run_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      run_r <= run_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    if (ctl_in.start) begin
      den_r <= den;
    end
  end

  assign quo = q_r;
  assign ctl_out = '{start: 1'b0, done: done_r};

endmodule

>>> tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 1500000;
  localparam int TAIL_CYCLES    = 500;
  localparam int LOW_IDLE_ITEMS = 150;
  localparam int DEPTH          = 1 << 18;
  localparam int NE             = dcvp_pkg::NUM_EDGES;

  localparam int EDGE_A [NE] = '{0, 1, 4, 0, 2, 3, 6, 2, 0, 1, 5, 4};
  localparam int EDGE_B [NE] = '{1, 5, 5, 4, 3, 7, 7, 6, 2, 3, 7, 6};
  localparam logic [1:0] EDGE_AX [NE] =
    '{dcvp_pkg::AX_X, dcvp_pkg::AX_Z, dcvp_pkg::AX_X, dcvp_pkg::AX_Z,
      dcvp_pkg::AX_X, dcvp_pkg::AX_Z, dcvp_pkg::AX_X, dcvp_pkg::AX_Z,
      dcvp_pkg::AX_Y, dcvp_pkg::AX_Y, dcvp_pkg::AX_Y, dcvp_pkg::AX_Y};

  typedef struct {
    bit                         is_cfg;
    logic [dcvp_pkg::ISO_W-1:0] iso;
    dcvp_pkg::in_req_t          req;
  } job_t;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  dcvp_pkg::in_req_t in_req;
  logic out_valid;
  dcvp_pkg::out_res_t out_res;
  logic cfg_we;
  logic [dcvp_pkg::ISO_W-1:0] cfg_wdata;

  dual_contour_vertex_placement uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .out_valid(out_valid), .out_res(out_res), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  job_t pending[$];
  dcvp_pkg::out_res_t vertex_q[$];
  int errors = 0;

  // predictor state
  logic [dcvp_pkg::ISO_W-1:0] iso_now = dcvp_pkg::ISO_RESET;
  bit cell_cached [DEPTH];
  logic [dcvp_pkg::POS_W-1:0] cached_x [DEPTH];
  logic [dcvp_pkg::POS_W-1:0] cached_y [DEPTH];
  logic [dcvp_pkg::POS_W-1:0] cached_z [DEPTH];
  logic [dcvp_pkg::TOTAL_W-1:0] point_total = '0;

  function automatic longint crossing(input longint a, input longint b);
    longint num, den;
    num = longint'(iso_now) - 2 * a;
    den = 2 * (b - a);
    if (den < 0) begin
      num = -num;
      den = -den;
    end
    if (den == 0) return (num > 0) ? 65536 : 0;
    if (num <= 0) return 0;
    if (num >= den) return 65536;
    return (num << 16) / den;
  endfunction

  function automatic dcvp_pkg::out_res_t place_vertex(input dcvp_pkg::in_req_t r);
    dcvp_pkg::out_res_t res;
    logic [17:0] key;
    longint c [8];
    longint sum [3];
    longint base [3];
    int n;
    c = '{r.corner_000, r.corner_100, r.corner_010, r.corner_110,
          r.corner_001, r.corner_101, r.corner_011, r.corner_111};
    base = '{r.cell_x, r.cell_y, r.cell_z};
    for (int i = 0; i < 6; i++) begin
      key[3*i]   = r.cell_x[i];
      key[3*i+1] = r.cell_y[i];
      key[3*i+2] = r.cell_z[i];
    end
    res = '0;
    if (cell_cached[key]) begin
      res.pos_x = cached_x[key];
      res.pos_y = cached_y[key];
      res.pos_z = cached_z[key];
      res.from_cache = 1'b1;
    end else if (r.edge_mask == '0) begin
      res.pos_x = dcvp_pkg::POS_W'(base[0] << 16);
      res.pos_y = dcvp_pkg::POS_W'(base[1] << 16);
      res.pos_z = dcvp_pkg::POS_W'(base[2] << 16);
      res.no_edges = 1'b1;
    end else begin
      sum = '{0, 0, 0};
      n = 0;
      for (int e = 0; e < NE; e++) begin
        if (r.edge_mask[e]) begin
          n++;
          for (int k = 0; k < 3; k++) begin
            if (k == int'(EDGE_AX[e])) sum[k] += crossing(c[EDGE_A[e]], c[EDGE_B[e]]);
            else if ((EDGE_A[e] >> k) & 1) sum[k] += 65536;
          end
        end
      end
      res.pos_x = dcvp_pkg::POS_W'((base[0] << 16) + sum[0] / n);
      res.pos_y = dcvp_pkg::POS_W'((base[1] << 16) + sum[1] / n);
      res.pos_z = dcvp_pkg::POS_W'((base[2] << 16) + sum[2] / n);
      cell_cached[key] = 1'b1;
      cached_x[key] = res.pos_x;
      cached_y[key] = res.pos_y;
      cached_z[key] = res.pos_z;
      if (point_total < DEPTH) point_total++;
    end
    res.stored_total = point_total;
    return res;
  endfunction

  // driver
  int gap = 0;
  int quiet = 0;
  logic nxt_start, nxt_we;
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      cfg_we <= 1'b0;
      gap = 0;
      quiet = 0;
    end else begin
      nxt_start = start;
      nxt_we = 1'b0;
      if (cfg_we) iso_now = cfg_wdata;
      if (start && !busy) begin
        vertex_q.push_back(place_vertex(in_req));
        void'(pending.pop_front());
        nxt_start = 1'b0;
        if ($urandom_range(0, 3) == 0 && pending.size() > LOW_IDLE_ITEMS)
          gap = $urandom_range(1, 11);
      end
      quiet = (vertex_q.size() == 0 && !busy && !start && !cfg_we) ? quiet + 1 : 0;
      if (!nxt_start && !cfg_we) begin
        if (gap > 0) begin
          gap--;
        end else if (pending.size() > 0) begin
          if (pending[0].is_cfg) begin
            // register writes only once the block has drained
            if (quiet >= 8) begin
              nxt_we = 1'b1;
              cfg_wdata <= pending[0].iso;
              void'(pending.pop_front());
              quiet = 0;
            end
          end else begin
            nxt_start = 1'b1;
            in_req <= pending[0].req;
          end
        end
      end
      start <= nxt_start;
      cfg_we <= nxt_we;
    end
  end

  // monitor
  task automatic check_field(input string name, input longint exp_v, input longint act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t: %s expected %0d got %0d", $time, name, exp_v, act_v);
    end
  endtask

  dcvp_pkg::out_res_t want;
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (vertex_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none got %p", $time, out_res);
      end else begin
        want = vertex_q.pop_front();
        check_field("pos_x", want.pos_x, out_res.pos_x);
        check_field("pos_y", want.pos_y, out_res.pos_y);
        check_field("pos_z", want.pos_z, out_res.pos_z);
        check_field("from_cache", want.from_cache, out_res.from_cache);
        check_field("no_edges", want.no_edges, out_res.no_edges);
        check_field("stored_total", want.stored_total, out_res.stored_total);
      end
    end
  end

  // watchdog, generous enough for the clearing pass after reset
  int stuck = 0;
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || cfg_we) stuck = 0;
    else stuck++;
    if (stuck >= WATCHDOG_LIMIT) begin
      $display("dual_contour_vertex_placement regression: fail");
      $finish;
    end
  end

  // stimulus
  task automatic add_cell(input logic [5:0] x, input logic [5:0] y, input logic [5:0] z,
                          input logic [11:0] m, input logic [15:0] c [8]);
    job_t j;
    j.is_cfg = 1'b0;
    j.iso = '0;
    j.req = {x, y, z, m, c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]};
    pending.push_back(j);
  endtask

  task automatic add_iso(input logic [dcvp_pkg::ISO_W-1:0] v);
    job_t j;
    j.is_cfg = 1'b1;
    j.iso = v;
    j.req = '0;
    pending.push_back(j);
  endtask

  task automatic add_random(input logic [dcvp_pkg::ISO_W-1:0] iso_v);
    logic [15:0] c [8];
    logic [5:0] x, y, z;
    logic [11:0] m;
    int mid, mode;
    if ($urandom_range(0, 9) < 7) begin
      // small neighborhood so cells are revisited
      x = 6'($urandom_range(0, 3));
      y = 6'($urandom_range(0, 3));
      z = 6'($urandom_range(0, 3));
    end else begin
      x = 6'($urandom);
      y = 6'($urandom);
      z = 6'($urandom);
    end
    case ($urandom_range(0, 9))
      0:       m = '0;
      1:       m = 12'd1 << $urandom_range(0, 11);
      2:       m = 12'hfff;
      default: m = 12'($urandom);
    endcase
    mid = int'(iso_v) / 2;
    mode = $urandom_range(0, 5);
    for (int i = 0; i < 8; i++) begin
      if (mode < 3) begin
        int v;
        v = mid + int'($urandom_range(0, 6000)) - 3000;
        c[i] = (v < 0) ? 16'd0 : (v > 65535) ? 16'hffff : v[15:0];
      end else if (mode == 3) begin
        c[i] = (i == 0) ? 16'($urandom) : c[0];
      end else begin
        c[i] = 16'($urandom);
      end
    end
    add_cell(x, y, z, m, c);
  endtask

  initial begin
    logic [15:0] c [8];
    logic [dcvp_pkg::ISO_W-1:0] isos [7];
    rst_n = 1'b0;
    start = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = dcvp_pkg::ISO_RESET;
    in_req = '0;

    // directed cells at the reset threshold
    c = '{default: 16'h0000};
    add_cell(6'd0, 6'd0, 6'd0, 12'h000, c);
    c = '{default: 16'hffff};
    add_cell(6'd63, 6'd63, 6'd63, 12'h000, c);
    for (int e = 0; e < NE; e++) begin
      for (int i = 0; i < 8; i++) c[i] = 16'($urandom);
      c[EDGE_A[e]] = 16'h0000;
      c[EDGE_B[e]] = (e % 2) ? 16'hffff : 16'h9000;
      add_cell(6'(e + 8), 6'd1, 6'd2, 12'd1 << e, c);
    end
    c = '{16'h0000, 16'hffff, 16'hffff, 16'h0000, 16'hffff, 16'h0000, 16'h0000, 16'hffff};
    add_cell(6'd63, 6'd0, 6'd63, 12'hfff, c);
    // equal samples on every edge, threshold above then below
    c = '{default: 16'h1234};
    add_cell(6'd5, 6'd9, 6'd33, 12'hfff, c);
    c = '{default: 16'hffff};
    add_cell(6'd6, 6'd9, 6'd33, 12'hfff, c);
    // revisit: stored point comes back whatever the new data; the empty-mask cell was not stored
    c = '{default: 16'h4000};
    add_cell(6'd63, 6'd0, 6'd63, 12'h0a5, c);
    add_cell(6'd0, 6'd0, 6'd0, 12'hfff, c);
    add_cell(6'd0, 6'd0, 6'd0, 12'h000, c);
    // crossing at exactly half of each x edge, then a y edge with equal samples
    c = '{16'd32767, 16'd32768, 16'd32767, 16'd32768,
          16'd32767, 16'd32768, 16'd32767, 16'd32768};
    add_cell(6'd20, 6'd40, 6'd60, 12'h055, c);
    add_cell(6'd42, 6'd21, 6'd63, 12'h800, c);

    isos = '{17'd0, 17'd131070, 17'($urandom), 17'($urandom_range(1, 131069)),
             17'd1, 17'($urandom_range(0, 131070)), 17'd65535};
    foreach (isos[p]) begin
      add_iso(isos[p]);
      for (int i = 0; i < 200; i++) add_random(isos[p]);
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (pending.size() > 0 || vertex_q.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) $display("dual_contour_vertex_placement regression: pass");
    else $display("dual_contour_vertex_placement regression: fail");
    $finish;
  end

endmodule
